// ===== rtl/crre_pkg.sv =====
// Shared types, constants and fixed-point helpers for the CSR row relaxation engine.
package crre_pkg;

  // Store geometry, set by the 10-bit column and row fields
  localparam int ADDR_W      = 10;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int DATA_W      = 32;

  // Item kinds
  localparam logic [1:0] KIND_X_LOAD = 2'd0;
  localparam logic [1:0] KIND_B_LOAD = 2'd1;
  localparam logic [1:0] KIND_ELEM   = 2'd2;

  // Operating modes
  localparam logic [1:0] MODE_MUL    = 2'd0;
  localparam logic [1:0] MODE_JACOBI = 2'd1;
  localparam logic [1:0] MODE_GS     = 2'd2;

  // Unit weight in Q16.16
  localparam logic [17:0] OMEGA_ONE = 18'd65536;

  // Input beat
  typedef struct packed {
    logic [1:0]               kind;
    logic [ADDR_W-1:0]        column;
    logic [ADDR_W-1:0]        row;
    logic signed [DATA_W-1:0] value;
    logic                     row_last;
  } item_t;

  // Result beat
  typedef struct packed {
    logic [ADDR_W-1:0]        result_row;
    logic signed [DATA_W-1:0] result_value;
    logic                     zero_diagonal;
    logic                     saturated;
  } result_t;

  // Clipped Q16.16 value with its clip flag
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } qval_t;

  // Clip a 65-bit signed sum to the signed 64-bit range
  function automatic logic signed [63:0] sat64(input logic signed [64:0] t);
    logic signed [63:0] r;
    if (t[64] != t[63]) begin
      r = t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = t[63:0];
    end
    return r;
  endfunction

  // Q32.32 to Q16.16, round half up, clipped to 32 bits
  function automatic qval_t round_q(input logic signed [63:0] v);
    logic signed [64:0] t;
    logic signed [48:0] s;
    qval_t r;
    t = {v[63], v} + 65'sd32768;
    s = t[64:16];
    if (s[48:31] != {18{s[48]}}) begin
      r.sat = 1'b1;
      r.val = s[48] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      r.sat = 1'b0;
      r.val = s[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/crre_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module crre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/crre_mul.sv =====
// Shared 32x32 signed multiplier with registered product.
module crre_mul import crre_pkg::*; (
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [63:0]       p
);

  // One product per cycle, registered
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/crre_div.sv =====
// Radix-2 restoring divider: 64-bit unsigned dividend by 32-bit unsigned divisor.
module crre_div import crre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient,
  output logic        done
);

  logic [63:0] dvd;
  logic [32:0] rem;
  logic [31:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] rem_sh;
  logic [33:0] diff;

  // Trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem[31:0], dvd[63]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr};
  end

  // One quotient bit a cycle; quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
        cnt  <= 7'd64;
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[33]) begin
          rem <= diff[32:0];
          dvd <= {dvd[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          dvd <= {dvd[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

// ===== rtl/csr_row_relaxation_engine.sv =====
// Top level of the CSR row relaxation engine: sequencer, stores and configuration port.
//
// Load beats (kind 0/1) write x or b. A matrix element is accepted with its x read,
// multiplied in the shared 32x32 multiplier and accumulated into the saturating Q32.32
// accumulator (in Jacobi and Gauss-Seidel modes the diagonal is held instead). The row's
// last element is then finished and emitted once the output register is free: multiply
// mode rounds the sum; relaxation modes divide b minus the sum by the diagonal in the
// bit-serial divider, Jacobi then blending; a zero diagonal gives the old x. Items are
// accepted only while the sequencer is idle; a finished result sits in an output
// register, so loads and elements of the next row go on while it waits to be taken.
// x and b are single RAMs with registered reads and no reset; reading a position never
// loaded gives an unspecified value.
module csr_row_relaxation_engine import crre_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  // Item channel
  input  logic          item_valid,
  output logic          item_ready,
  input  item_t         item,
  // Result channel
  output logic          result_valid,
  input  logic          result_ready,
  output result_t       result,
  // Configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_OMEGA = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ROW,
    ST_DIV_GO,
    ST_DIV,
    ST_QUOT,
    ST_BLEND1,
    ST_BLEND2,
    ST_BLEND3,
    ST_EMIT
  } state_t;

  state_t                   state;
  logic [1:0]               mode;
  logic [17:0]              omega;
  item_t                    item_q;
  logic                     is_diag;
  logic signed [63:0]       acc;
  logic signed [DATA_W-1:0] diag;
  logic signed [DATA_W-1:0] qv;
  logic signed [DATA_W-1:0] res;
  logic                     neg;
  logic                     zdiag;
  logic                     sat_f;

  logic                     relax;
  logic                     accept;
  logic                     cfg_wr;

  // Store ports
  logic                     x_we;
  logic [ADDR_W-1:0]        x_waddr;
  logic [DATA_W-1:0]        x_wdata;
  logic [ADDR_W-1:0]        x_raddr;
  logic [DATA_W-1:0]        x_q;
  logic                     b_we;
  logic [ADDR_W-1:0]        b_raddr;
  logic [DATA_W-1:0]        b_q;

  // Shared units
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [63:0]       prod;
  logic                     div_start;
  logic [63:0]              div_dividend;
  logic [31:0]              div_divisor;
  logic [63:0]              div_quot;
  logic                     div_done;

  // Datapath values
  logic signed [63:0]       acc_sum;
  logic signed [63:0]       num;
  logic signed [63:0]       blend;
  logic signed [DATA_W-1:0] wt;
  qval_t                    rnd;
  qval_t                    qclip;

  assign relax      = (mode == MODE_JACOBI) || (mode == MODE_GS);
  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign cfg_wr     = psel && penable && pwrite;
  assign pready     = 1'b1;

  // Register read-back
  always_comb begin
    if (paddr[2] == REG_MODE) begin
      prdata = {30'd0, mode};
    end else begin
      prdata = {14'd0, omega};
    end
  end

  // Store addressing: element column on accept, otherwise the held row
  always_comb begin
    x_raddr = (state == ST_IDLE) ? item.column : item_q.row;
    b_raddr = (state == ST_IDLE) ? item.row : item_q.row;
    b_we    = accept && (item.kind == KIND_B_LOAD);
    if (state == ST_QUOT) begin
      x_we    = (mode == MODE_GS);
      x_waddr = item_q.row;
      x_wdata = qv;
    end else begin
      x_we    = accept && (item.kind == KIND_X_LOAD);
      x_waddr = item.column;
      x_wdata = item.value;
    end
  end

  crre_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_x_store (
    .clk   (clk),
    .we    (x_we),
    .waddr (x_waddr),
    .wdata (x_wdata),
    .raddr (x_raddr),
    .rdata (x_q)
  );

  crre_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (item.column),
    .wdata (item.value),
    .raddr (b_raddr),
    .rdata (b_q)
  );

  // Multiplier operand selection
  assign wt = 32'sd65536 - $signed({14'd0, omega});
  always_comb begin
    unique case (state)
      ST_BLEND1: begin
        mul_a = wt;
        mul_b = x_q;
      end
      ST_BLEND2: begin
        mul_a = $signed({14'd0, omega});
        mul_b = qv;
      end
      default: begin
        mul_a = item_q.value;
        mul_b = x_q;
      end
    endcase
  end

  crre_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Divider operands: magnitudes of the held numerator and the diagonal
  assign div_start    = (state == ST_DIV_GO);
  assign div_dividend = acc[63] ? (64'd0 - acc) : acc;
  assign div_divisor  = diag[31] ? (32'd0 - diag) : diag;

  crre_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .done     (div_done)
  );

  // Accumulate, numerator, blend and rounding
  always_comb begin
    acc_sum = sat64({acc[63], acc} + {prod[63], prod});
    num     = sat64({{17{b_q[31]}}, b_q, 16'd0} - {acc[63], acc});
    blend   = acc + prod;
    rnd     = round_q((state == ST_BLEND3) ? blend : acc);
  end

  // Signed quotient, clipped to 32 bits
  always_comb begin
    if (neg) begin
      qclip.sat = (div_quot[63:32] != 32'd0) || (div_quot[31] && (div_quot[30:0] != 31'd0));
      qclip.val = qclip.sat ? {1'b1, 31'd0} : (32'd0 - div_quot[31:0]);
    end else begin
      qclip.sat = (div_quot[63:31] != 33'd0);
      qclip.val = qclip.sat ? {1'b0, {31{1'b1}}} : div_quot[31:0];
    end
  end

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mode         <= MODE_MUL;
      omega        <= OMEGA_ONE;
      acc          <= '0;
      diag         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_MODE) begin
          mode <= pwdata[1:0];
        end else if (paddr[2] == REG_OMEGA) begin
          omega <= pwdata[17:0];
        end
      end
      // A taken beat frees the output register; ST_EMIT reloads it itself
      if (result_valid && result_ready && (state != ST_EMIT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (item.kind == KIND_ELEM)) begin
            item_q  <= item;
            is_diag <= relax && (item.column == item.row);
            if (relax && (item.column == item.row)) begin
              diag <= item.value;
            end
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (!is_diag) begin
            acc <= acc_sum;
          end
          state <= item_q.row_last ? ST_ROW : ST_IDLE;
        end
        ST_ROW: begin
          zdiag <= 1'b0;
          if (!relax) begin
            res   <= rnd.val;
            sat_f <= rnd.sat;
            state <= ST_EMIT;
          end else if (diag == '0) begin
            res   <= x_q;
            zdiag <= 1'b1;
            sat_f <= 1'b0;
            state <= ST_EMIT;
          end else begin
            acc   <= num;
            neg   <= num[63] ^ diag[31];
            state <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            qv    <= qclip.val;
            sat_f <= qclip.sat;
            state <= ST_QUOT;
          end
        end
        ST_QUOT: begin
          // Gauss-Seidel writes the quotient back this cycle
          if (mode == MODE_GS) begin
            res   <= qv;
            state <= ST_EMIT;
          end else begin
            state <= ST_BLEND1;
          end
        end
        ST_BLEND1: begin
          state <= ST_BLEND2;
        end
        ST_BLEND2: begin
          acc   <= prod;
          state <= ST_BLEND3;
        end
        ST_BLEND3: begin
          res   <= rnd.val;
          sat_f <= sat_f | rnd.sat;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!result_valid || result_ready) begin
            result_valid         <= 1'b1;
            result.result_row    <= item_q.row;
            result.result_value  <= res;
            result.zero_diagonal <= zdiag;
            result.saturated     <= sat_f;
            acc                  <= '0;
            diag                 <= '0;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
